/* rtl/core/sts_pkg.sv */
// ============================================================================
// sts_pkg: shared definitions for the session token table
// Command and status codes, payload widths and the token generator step.
// ============================================================================
package sts_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 128;
    localparam int DEFAULT_OWNER_BITS  = 32;

    localparam int CMD_BITS     = 2;
    localparam int USER_BITS    = 32;
    localparam int KEY_BITS     = 64;
    localparam int TOKEN_BITS   = 128;
    localparam int STATUS_BITS  = 2;
    localparam int USED_BITS    = 8;

    // Each draw is the generator state modulo this value.
    localparam int DRAW_MODULUS = 32'h10000;
    localparam int DRAW_BITS    = $clog2(DRAW_MODULUS);
    localparam int DRAW_COUNT   = TOKEN_BITS / DRAW_BITS;

    localparam logic [CMD_BITS-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_END    = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

    // One xorshift64 step with shifts 13, 7 and 17.
    function automatic logic [63:0] sts_xorshift(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction

endpackage

/* rtl/core/sts_if.sv */
// ============================================================================
// sts_if: request and response channels of the session token table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface sts_req_if
    import sts_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_BITS-1:0]  cmd;
    logic [USER_BITS-1:0] user_number;
    logic [KEY_BITS-1:0]  key_high;
    logic [KEY_BITS-1:0]  key_low;

    modport source (output valid, cmd, user_number, key_high, key_low, input ready);
    modport sink   (input valid, cmd, user_number, key_high, key_low, output ready);
endinterface

interface sts_rsp_if
    import sts_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic                   found;
    logic [USER_BITS-1:0]   owner_number;
    logic [KEY_BITS-1:0]    token_high;
    logic [KEY_BITS-1:0]    token_low;
    logic [USED_BITS-1:0]   entries_used;

    modport source (output valid, status, found, owner_number, token_high, token_low,
                    entries_used, input ready);
    modport sink   (input valid, status, found, owner_number, token_high, token_low,
                    entries_used, output ready);
endinterface

/* rtl/core/session_token_table_unit.sv */
// ============================================================================
// session_token_table_unit: session token table with linear search
// Creates random 128-bit session tokens, looks them up and ends sessions.
// ============================================================================
// Usage:
// Commands arrive on the request channel and each produces one transfer on
// the response channel. One command is worked on at a time; request.ready is
// high while the sequencer is idle, also while a finished response still
// waits in the output register for the receiver.
// Create runs eight generator steps, one per cycle, then a write.
// Create into a full table skips the generator steps and the write.
// Lookup reads the live entries in order until the first match or the count;
// End then walks the entries after the match, moves each down one slot and
// lowers the count. A new command can be taken in the cycle after the
// response loads. Both walks use the single table memory, one read and one
// write per cycle, with registered read data.
// cfg_write_en loads the generator with cfg_write_data (zero loads as one);
// write it only while the block is idle.
// Reset empties the table and loads the generator with one; the table memory
// needs no clearing pass since only entries below the count are read.
// A stalled receiver holds the response; the block then takes at most one
// more command and holds its result until the output register frees.
// ============================================================================
module session_token_table_unit
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int OWNER_BITS  = DEFAULT_OWNER_BITS
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic [63:0]   cfg_write_data,
    sts_req_if.sink       request,
    sts_rsp_if.source     response
);

    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WW  = TOKEN_BITS + OWNER_BITS;
    localparam int DCW = (DRAW_COUNT > 1) ? $clog2(DRAW_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_WRITE,
        ST_SEARCH,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [63:0]            gen_reg;
    logic [CMD_BITS-1:0]    cmd_reg;
    logic [USER_BITS-1:0]   user_reg;
    logic [KEY_BITS-1:0]    key_hi_reg;
    logic [KEY_BITS-1:0]    key_lo_reg;
    logic [TOKEN_BITS-1:0]  tok_reg;
    logic [DCW-1:0]         draw_cnt_reg;
    logic [CW-1:0]          scan_reg;
    logic                   pend_reg;
    logic [AW-1:0]          pend_idx_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic                   found_reg;
    logic [USER_BITS-1:0]   owner_reg;

    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic                   out_found_reg;
    logic [USER_BITS-1:0]   out_owner_reg;
    logic [TOKEN_BITS-1:0]  out_token_reg;
    logic [USED_BITS-1:0]   out_used_reg;

    logic [WW-1:0]          mem_array [TABLE_DEPTH];
    logic [WW-1:0]          rdata_reg;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WW-1:0]          wr_data;
    logic                   scan_lt;
    logic                   match;
    logic [63:0]            gen_next;
    logic [63:0]            user_wide;
    logic [63:0]            owner_wide;
    logic [CW+7:0]          count_wide;

    assign scan_lt    = scan_reg < count_reg;
    assign rd_en      = (state_reg == ST_SEARCH || state_reg == ST_SHIFT) && scan_lt;
    assign rd_addr    = scan_reg[AW-1:0];
    assign match      = pend_reg
                        && rdata_reg[WW-1 -: KEY_BITS] == key_hi_reg
                        && rdata_reg[OWNER_BITS +: KEY_BITS] == key_lo_reg;
    assign gen_next   = sts_xorshift(gen_reg);
    assign user_wide  = 64'(user_reg);
    assign owner_wide = 64'(rdata_reg[OWNER_BITS-1:0]);
    assign count_wide = (CW + 8)'(count_reg);

    // During the shift walk each entry read in the previous cycle moves down one slot.
    assign wr_en   = (state_reg == ST_WRITE) || (state_reg == ST_SHIFT && pend_reg);
    assign wr_addr = (state_reg == ST_WRITE) ? count_reg[AW-1:0]
                                             : pend_idx_reg - AW'(1);
    assign wr_data = (state_reg == ST_WRITE) ? {tok_reg, user_wide[OWNER_BITS-1:0]}
                                             : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem_array[rd_addr];
        end
    end

    assign request.ready         = (state_reg == ST_IDLE);
    assign response.valid        = out_valid_reg;
    assign response.status       = out_status_reg;
    assign response.found        = out_found_reg;
    assign response.owner_number = out_owner_reg;
    assign response.token_high   = out_token_reg[TOKEN_BITS-1 -: KEY_BITS];
    assign response.token_low    = out_token_reg[KEY_BITS-1:0];
    assign response.entries_used = out_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            gen_reg       <= 64'd1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                gen_reg <= (cfg_write_data != 64'd0) ? cfg_write_data : 64'd1;
            end
            // The finish state reloads the output register in the same cycle.
            if (response.ready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (request.valid)
                    begin
                        cmd_reg      <= request.cmd;
                        user_reg     <= request.user_number;
                        key_hi_reg   <= request.key_high;
                        key_lo_reg   <= request.key_low;
                        tok_reg      <= '0;
                        found_reg    <= 1'b0;
                        owner_reg    <= '0;
                        status_reg   <= (request.cmd == CMD_CREATE
                                         && count_reg == CW'(TABLE_DEPTH))
                                        ? STATUS_FULL : STATUS_NOT_FOUND;
                        scan_reg     <= '0;
                        pend_reg     <= 1'b0;
                        draw_cnt_reg <= '0;
                        case (request.cmd) inside
                            CMD_CREATE:
                            begin
                                if (count_reg == CW'(TABLE_DEPTH))
                                begin
                                    state_reg <= ST_FINISH;
                                end
                                else
                                begin
                                    state_reg <= ST_GEN;
                                end
                            end
                            CMD_LOOKUP, CMD_END:
                            begin
                                state_reg <= ST_SEARCH;
                            end
                            default:
                            begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_GEN:
                begin
                    gen_reg      <= gen_next;
                    tok_reg      <= {tok_reg[TOKEN_BITS-DRAW_BITS-1:0],
                                     gen_next[DRAW_BITS-1:0]};
                    draw_cnt_reg <= draw_cnt_reg + DCW'(1);
                    if (draw_cnt_reg == DCW'(DRAW_COUNT - 1))
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    count_reg  <= count_reg + CW'(1);
                    status_reg <= STATUS_OK;
                    state_reg  <= ST_FINISH;
                end
                ST_SEARCH:
                begin
                    pend_idx_reg <= rd_addr;
                    if (match && cmd_reg == CMD_END)
                    begin
                        // Start the walk at the entry after the match.
                        scan_reg <= CW'(pend_idx_reg) + CW'(1);
                        pend_reg <= 1'b0;
                    end
                    else
                    begin
                        pend_reg <= rd_en;
                        if (rd_en)
                        begin
                            scan_reg <= scan_reg + CW'(1);
                        end
                    end
                    if (match)
                    begin
                        found_reg  <= 1'b1;
                        status_reg <= STATUS_OK;
                        owner_reg  <= owner_wide[USER_BITS-1:0];
                        if (cmd_reg == CMD_END)
                        begin
                            state_reg <= ST_SHIFT;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                    else if (!pend_reg && !scan_lt)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_SHIFT:
                begin
                    pend_reg     <= rd_en;
                    pend_idx_reg <= rd_addr;
                    if (rd_en)
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                    if (!pend_reg && !scan_lt)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || response.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_found_reg  <= found_reg;
                        out_owner_reg  <= owner_reg;
                        out_token_reg  <= tok_reg;
                        out_used_reg   <= count_wide[USED_BITS-1:0];
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != 64'd0)
        else $error("token generator reached zero");

    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |=> count_reg == $past(count_reg) + CW'(1))
        else $error("create did not advance the entry count");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == ST_SHIFT) |-> CW'(wr_addr) < count_reg)
        else $error("shift walk wrote beyond the live entries");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !response.ready) |=> out_valid_reg)
        else $error("stalled response was dropped");
`endif

endmodule

/* tb/sv/tb.sv */
// ============================================================================
// tb: self-checking testbench for session_token_table_unit
// Drives create, lookup, end and unused commands over the request channel and checks
// every response against an in-bench model of the token table and generator.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sts_pkg::*;

    localparam int TABLE_SIZE = DEFAULT_TABLE_DEPTH;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int BASE_IDLE_PCT = 28;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   found;
        logic [USER_BITS-1:0]   owner_number;
        logic [KEY_BITS-1:0]    token_high;
        logic [KEY_BITS-1:0]    token_low;
        logic [USED_BITS-1:0]   entries_used;
    } session_reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [63:0] cfg_write_data;

    sts_req_if req_ch();
    sts_rsp_if rsp_ch();

    session_token_table_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .request        (req_ch),
        .response       (rsp_ch)
    );

    // Model of the session table and the token generator.
    logic [KEY_BITS-1:0]  sess_token_hi [TABLE_SIZE];
    logic [KEY_BITS-1:0]  sess_token_lo [TABLE_SIZE];
    logic [USER_BITS-1:0] sess_owner    [TABLE_SIZE];
    int                   live_count;
    logic [63:0]          gen_state;

    session_reply_t pending_replies[$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;

    function automatic logic [15:0] draw_token_piece();
        logic [63:0] x;
        x = gen_state;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        gen_state = x;
        return x[15:0];
    endfunction

    function automatic session_reply_t apply_session_cmd(input logic [CMD_BITS-1:0] c,
                                                         input logic [USER_BITS-1:0] user,
                                                         input logic [KEY_BITS-1:0] kh,
                                                         input logic [KEY_BITS-1:0] kl);
        session_reply_t r;
        int pos;
        int i;
        int k;
        r = '0;
        r.status = STATUS_NOT_FOUND;
        pos = -1;
        if (c == CMD_CREATE)
        begin
            if (live_count >= TABLE_SIZE)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                for (k = 0; k < 4; k++)
                    r.token_high = {r.token_high[47:0], draw_token_piece()};
                for (k = 0; k < 4; k++)
                    r.token_low = {r.token_low[47:0], draw_token_piece()};
                sess_token_hi[live_count] = r.token_high;
                sess_token_lo[live_count] = r.token_low;
                sess_owner[live_count] = user;
                live_count++;
                r.status = STATUS_OK;
            end
        end
        else if (c == CMD_LOOKUP || c == CMD_END)
        begin
            for (i = 0; i < live_count && pos < 0; i++)
                if (sess_token_hi[i] == kh && sess_token_lo[i] == kl)
                    pos = i;
            if (pos >= 0)
            begin
                r.status = STATUS_OK;
                r.found = 1'b1;
                r.owner_number = sess_owner[pos];
                if (c == CMD_END)
                begin
                    // The first match goes away and later entries move down by one.
                    for (i = pos; i + 1 < live_count; i++)
                    begin
                        sess_token_hi[i] = sess_token_hi[i + 1];
                        sess_token_lo[i] = sess_token_lo[i + 1];
                        sess_owner[i] = sess_owner[i + 1];
                    end
                    live_count--;
                end
            end
        end
        r.entries_used = live_count[USED_BITS-1:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("** session_token_table_unit: FAILED **");
        $finish;
    end

    // Response side: random stalls and in-order comparison of every transfer.
    initial
    begin
        session_reply_t got;
        session_reply_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got = {rsp_ch.status, rsp_ch.found, rsp_ch.owner_number,
                       rsp_ch.token_high, rsp_ch.token_low, rsp_ch.entries_used};
                if (pending_replies.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("response with no command outstanding: status %0d used %0d",
                                 got.status, got.entries_used);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("mismatch: expected status %0d found %0d owner %h token %h_%h used %0d",
                                     want.status, want.found, want.owner_number,
                                     want.token_high, want.token_low, want.entries_used);
                            $display("          actual   status %0d found %0d owner %h token %h_%h used %0d",
                                     got.status, got.found, got.owner_number,
                                     got.token_high, got.token_low, got.entries_used);
                        end
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [CMD_BITS-1:0] c, input logic [USER_BITS-1:0] user,
                             input logic [KEY_BITS-1:0] kh, input logic [KEY_BITS-1:0] kl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= c;
        req_ch.user_number <= user;
        req_ch.key_high <= kh;
        req_ch.key_low <= kl;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_replies.push_back(apply_session_cmd(c, user, kh, kl));
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_seed(input logic [63:0] seed);
        drain_replies();
        repeat (4) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= seed;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        gen_state = (seed == 64'd0) ? 64'd1 : seed;
    endtask

    task automatic send_random_item();
        logic [CMD_BITS-1:0] c;
        logic [KEY_BITS-1:0] kh;
        logic [KEY_BITS-1:0] kl;
        int pick;
        int idx;
        int flip;
        int create_weight;
        kh = {$urandom, $urandom};
        kl = {$urandom, $urandom};
        // Creates outweigh ends while the table is sparse, so the count wanders
        // around the middle of the table.
        create_weight = (live_count < 64) ? 40 : 20;
        pick = $urandom_range(99);
        if (pick < create_weight)
        begin
            c = CMD_CREATE;
        end
        else if (pick < 90)
        begin
            c = ($urandom_range(1) == 0) ? CMD_LOOKUP : CMD_END;
            if (live_count > 0)
            begin
                idx = $urandom_range(live_count - 1);
                kh = sess_token_hi[idx];
                kl = sess_token_lo[idx];
                if ($urandom_range(9) == 0)
                begin
                    flip = $urandom_range(127);
                    if (flip < 64)
                        kh[flip] = ~kh[flip];
                    else
                        kl[flip - 64] = ~kl[flip - 64];
                end
            end
        end
        else if (pick < 97)
        begin
            c = ($urandom_range(1) == 0) ? CMD_LOOKUP : CMD_END;
        end
        else
        begin
            c = CMD_UNUSED;
        end
        send_item(c, $urandom, kh, kl);
    endtask

    task automatic test_empty_table();
        send_item(CMD_LOOKUP, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(CMD_END, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(CMD_LOOKUP, '0, '0, '0);
        send_item(CMD_END, '1, '1, '1);
        send_item(CMD_UNUSED, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic test_create_lookup_end();
        logic [KEY_BITS-1:0] kh;
        logic [KEY_BITS-1:0] kl;
        send_item(CMD_CREATE, '0, '0, '0);
        send_item(CMD_CREATE, '1, '1, '1);
        repeat (3) send_item(CMD_CREATE, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(CMD_LOOKUP, $urandom, sess_token_hi[0], sess_token_lo[0]);
        send_item(CMD_LOOKUP, $urandom, sess_token_hi[live_count - 1],
                  sess_token_lo[live_count - 1]);
        kh = sess_token_hi[2];
        kl = sess_token_lo[2];
        send_item(CMD_END, $urandom, kh, kl);
        send_item(CMD_LOOKUP, $urandom, kh, kl);
        send_item(CMD_END, $urandom, sess_token_hi[live_count - 1],
                  sess_token_lo[live_count - 1]);
        send_item(CMD_END, $urandom, sess_token_hi[0], sess_token_lo[0]);
        // A token one bit away from a live one must not match.
        send_item(CMD_LOOKUP, $urandom, sess_token_hi[0] ^ 64'h1, sess_token_lo[0]);
        send_item(CMD_UNUSED, $urandom, sess_token_hi[0], sess_token_lo[0]);
    endtask

    task automatic test_seed_values();
        load_seed(64'd0);
        send_item(CMD_CREATE, $urandom, '0, '0);
        // Seed one repeats the token just made, so the table holds a duplicate.
        load_seed(64'd1);
        send_item(CMD_CREATE, $urandom, '0, '0);
        send_item(CMD_END, $urandom, sess_token_hi[live_count - 1],
                  sess_token_lo[live_count - 1]);
        load_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_CREATE, $urandom, '0, '0);
    endtask

    task automatic test_full_table();
        load_seed({$urandom, $urandom});
        while (live_count < TABLE_SIZE)
            send_item(CMD_CREATE, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(CMD_CREATE, '1, '1, '1);
        send_item(CMD_CREATE, $urandom, '0, '0);
        send_item(CMD_LOOKUP, $urandom, sess_token_hi[TABLE_SIZE - 1],
                  sess_token_lo[TABLE_SIZE - 1]);
        send_item(CMD_END, $urandom, sess_token_hi[0], sess_token_lo[0]);
        send_item(CMD_CREATE, $urandom, '0, '0);
        send_item(CMD_LOOKUP, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(CMD_END, $urandom, sess_token_hi[TABLE_SIZE - 1],
                  sess_token_lo[TABLE_SIZE - 1]);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_no_idle(input int count);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (count) send_random_item();
        send_idle_pct = BASE_IDLE_PCT;
        recv_idle_pct = BASE_IDLE_PCT;
    endtask

    task automatic test_paused_sender(input int count);
        test_random_mix(count);
        drain_replies();
        test_random_mix(count);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_write_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.cmd <= CMD_CREATE;
        req_ch.user_number <= '0;
        req_ch.key_high <= '0;
        req_ch.key_low <= '0;
        live_count = 0;
        gen_state = 64'd1;
        error_count = 0;
        send_idle_pct = BASE_IDLE_PCT;
        recv_idle_pct = BASE_IDLE_PCT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_create_lookup_end();
        test_seed_values();
        test_full_table();
        test_random_mix(600);
        load_seed({$urandom, $urandom});
        test_no_idle(400);
        test_paused_sender(300);
        load_seed({$urandom, $urandom});
        test_random_mix(300);

        drain_replies();
        repeat (300) @(posedge clk);
        error_count += pending_replies.size();
        if (error_count == 0)
            $display("** session_token_table_unit: PASSED **");
        else
            $display("** session_token_table_unit: FAILED **");
        $finish;
    end

endmodule
